[design/crc16_framed_packet_deframer_top_macros.svh]
// Assertion macros for the deframer's checker file.
`ifndef CRC16_FRAMED_PACKET_DEFRAMER_TOP_MACROS_SVH
`define CRC16_FRAMED_PACKET_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication, held off while reset is high.
`define CFD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off while reset is high.
`define CFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/cfd_pkg.sv]
// Types, codes and constants shared by the deframer files.
package cfd_pkg;

  localparam logic [7:0]  START_BYTE = 8'h55;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [7:0]  MIN_LENGTH = 8'd2;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_BYTE   = 2'd0;
  localparam kind_t KIND_GOOD   = 2'd1;
  localparam kind_t KIND_BADCRC = 2'd2;
  localparam kind_t KIND_BADLEN = 2'd3;

  typedef enum logic [4:0] {
    PH_HUNT   = 5'b00001,
    PH_LEN    = 5'b00010,
    PH_DATA   = 5'b00100,
    PH_CHK_HI = 5'b01000,
    PH_CHK_LO = 5'b10000
  } phase_t;

endpackage

[design/cfd_crc_byte.sv]
// Byte-wide CRC-16-CCITT update, MSB first, unrolled over the eight bits.
module cfd_crc_byte
  import cfd_pkg::*;
(
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

[design/crc16_framed_packet_deframer_top.sv]
// Top level of the start/length/payload/CRC-16 frame deframer.
//
// Input channel (s_*): one received serial byte per item in s_tdata.
// Output channel (m_*): results; m_tuser carries the kind (payload byte,
// frame good, checksum mismatch, bad length), m_tdata the payload byte
// and the frame's payload length.
// Bytes are dropped until the start byte 0x55. The next byte is the length;
// a length below 2 or above MAX_PAYLOAD gives a bad-length result. Payload
// bytes are passed on as they arrive, then two big-endian check bytes are
// compared with a CRC-16-CCITT over start, length and payload bytes, and
// a good or checksum-mismatch result ends the frame.
// An item sits in an input register, the frame logic and a byte-wide CRC
// update run on it combinationally, and the result lands in an output
// register. Throughput is one byte per cycle while m_tready stays high.
// Reset empties both registers and returns the deframer to hunting.
// When the receiver stalls, the result is held and one more byte waits in
// the input register; s_tready then drops until m_tready returns.
module crc16_framed_packet_deframer_top
  import cfd_pkg::*;
#(
  parameter int MAX_PAYLOAD = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [15:8] frame_length
  output logic [1:0]  m_tuser    // [1:0] out_kind
);

  localparam logic [8:0] MAX_LEN = 9'(MAX_PAYLOAD);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        out_valid;
  kind_t       out_kind;
  logic [7:0]  out_byte;
  logic [7:0]  out_len;

  phase_t      phase, phase_next;
  logic [7:0]  payload_length, payload_length_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  received_crc_high, received_crc_high_next;

  logic        res_valid;
  kind_t       res_kind;
  logic [7:0]  res_byte;
  logic [7:0]  res_len;

  logic        out_free;
  logic        consume;
  logic [15:0] crc_seed;
  logic [15:0] crc_fed;
  logic [7:0]  left_dec;

  assign out_free = !out_valid || m_tready;
  assign consume  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // A fresh frame starts its CRC from the initial value.
  assign crc_seed = (phase == PH_LEN || phase == PH_DATA) ? running_crc : CRC_INIT;
  assign left_dec = bytes_left - 8'd1;

  cfd_crc_byte u_crc (
    .crc_in  (crc_seed),
    .data    (in_byte),
    .crc_out (crc_fed)
  );

  always_comb begin
    phase_next             = phase;
    payload_length_next    = payload_length;
    bytes_left_next        = bytes_left;
    running_crc_next       = running_crc;
    received_crc_high_next = received_crc_high;
    res_valid              = 1'b0;
    res_kind               = KIND_BYTE;
    res_byte               = 8'h00;
    res_len                = payload_length;
    case (phase)
      PH_LEN: begin
        if (in_byte < MIN_LENGTH || {1'b0, in_byte} > MAX_LEN) begin
          phase_next = PH_HUNT;
          res_valid  = 1'b1;
          res_kind   = KIND_BADLEN;
          res_len    = in_byte;
        end else begin
          running_crc_next    = crc_fed;
          payload_length_next = in_byte;
          bytes_left_next     = in_byte;
          phase_next          = PH_DATA;
        end
      end
      PH_DATA: begin
        running_crc_next = crc_fed;
        bytes_left_next  = left_dec;
        if (left_dec == 8'd0) begin
          phase_next = PH_CHK_HI;
        end
        res_valid = 1'b1;
        res_kind  = KIND_BYTE;
        res_byte  = in_byte;
      end
      PH_CHK_HI: begin
        received_crc_high_next = in_byte;
        phase_next             = PH_CHK_LO;
      end
      PH_CHK_LO: begin
        phase_next = PH_HUNT;
        res_valid  = 1'b1;
        res_kind   = ({received_crc_high, in_byte} == running_crc) ? KIND_GOOD
                                                                   : KIND_BADCRC;
      end
      default: begin
        phase_next = PH_HUNT;
        if (in_byte == START_BYTE) begin
          running_crc_next = crc_fed;
          phase_next       = PH_LEN;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid          <= 1'b0;
      out_valid         <= 1'b0;
      phase             <= PH_HUNT;
      payload_length    <= 8'h00;
      bytes_left        <= 8'h00;
      running_crc       <= CRC_INIT;
      received_crc_high <= 8'h00;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (consume) begin
        in_valid <= 1'b0;
      end
      if (consume) begin
        out_valid         <= res_valid;
        phase             <= phase_next;
        payload_length    <= payload_length_next;
        bytes_left        <= bytes_left_next;
        running_crc       <= running_crc_next;
        received_crc_high <= received_crc_high_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
    if (consume && res_valid) begin
      out_kind <= res_kind;
      out_byte <= res_byte;
      out_len  <= res_len;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_len, out_byte};
  assign m_tuser  = out_kind;

endmodule

[design/cfd_checker.sv]
// Port-level checker for the deframer, bound to its top level.
`include "crc16_framed_packet_deframer_top_macros.svh"

module cfd_checker
  import cfd_pkg::*;
#(
  parameter int MAX_PAYLOAD = 255
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser
);

  localparam logic [8:0] MAX_LEN = 9'(MAX_PAYLOAD);

  logic [17:0] m_item;
  logic [7:0]  m_len;
  logic        len_ok;

  assign m_item = {m_tuser, m_tdata};
  assign m_len  = m_tdata[15:8];
  assign len_ok = (m_len >= MIN_LENGTH) && ({1'b0, m_len} <= MAX_LEN);

  // A stalled result keeps its kind and data.
  `CFD_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_item))

  // Only payload results carry a data byte.
  `CFD_ASSERT_NOW(a_status_byte_zero, m_tvalid && m_tuser != KIND_BYTE, m_tdata[7:0] == 8'h00)

  // A bad-length result reports a length outside the accepted range.
  `CFD_ASSERT_NOW(a_badlen_range, m_tvalid && m_tuser == KIND_BADLEN, !len_ok)

  // Every other result belongs to a frame whose length was accepted.
  `CFD_ASSERT_NOW(a_frame_len_ok, m_tvalid && m_tuser != KIND_BADLEN, len_ok)

  // With no result pending, an offered item is always taken.
  `CFD_ASSERT_NOW(a_ready_when_empty, s_tvalid && !m_tvalid, s_tready)

endmodule

bind crc16_framed_packet_deframer_top cfd_checker #(
  .MAX_PAYLOAD (MAX_PAYLOAD)
) u_cfd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

[tb/sv/crc16_framed_packet_deframer_top_tb.sv]
// Self-checking testbench for the CRC-16 framed packet deframer top level.
`timescale 1ns / 1ps

module crc16_framed_packet_deframer_top_tb;
  import cfd_pkg::*;

  localparam int MAX_PAYLOAD = 255;
  localparam int DIR_ROWS = 21;
  localparam int RX_BYTE_TARGET = 575;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] len;
  } deframe_result_t;

  typedef enum logic [1:0] {
    SRC_LIT,
    SRC_CRC_HI,
    SRC_CRC_LO,
    SRC_CRC_LO_BAD
  } byte_src_t;

  typedef struct packed {
    byte_src_t       src;
    logic [7:0]      rx;
    logic            typed;
    deframe_result_t res;
  } dir_row_t;

  localparam deframe_result_t NO_RESULT = '{KIND_BYTE, 8'h00, 8'h00};

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;

  // Predicted deframer state.
  phase_t      pred_phase;
  logic [7:0]  pred_len;
  logic [7:0]  pred_left;
  logic [15:0] pred_crc;
  logic [7:0]  pred_chk_hi;

  deframe_result_t expected_results_q[$];
  int  mismatches;
  int  rx_bytes_sent;
  bit  idle_ok;
  bit  hold_req;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{SRC_LIT,        8'h00, 1'b0, NO_RESULT},
    '{SRC_LIT,        8'hFF, 1'b0, NO_RESULT},
    '{SRC_LIT,        8'hAA, 1'b0, NO_RESULT},
    '{SRC_LIT,        8'h55, 1'b0, NO_RESULT},
    '{SRC_LIT,        8'h00, 1'b1, '{KIND_BADLEN, 8'h00, 8'h00}},
    '{SRC_LIT,        8'h55, 1'b0, NO_RESULT},
    '{SRC_LIT,        8'h01, 1'b1, '{KIND_BADLEN, 8'h00, 8'h01}},
    '{SRC_LIT,        8'h55, 1'b0, NO_RESULT},
    '{SRC_LIT,        8'h02, 1'b0, NO_RESULT},
    '{SRC_LIT,        8'h55, 1'b0, NO_RESULT},
    '{SRC_LIT,        8'hFF, 1'b0, NO_RESULT},
    '{SRC_CRC_HI,     8'h00, 1'b0, NO_RESULT},
    '{SRC_CRC_LO,     8'h00, 1'b1, '{KIND_GOOD, 8'h00, 8'h02}},
    '{SRC_LIT,        8'h55, 1'b0, NO_RESULT},
    '{SRC_LIT,        8'h03, 1'b0, NO_RESULT},
    '{SRC_LIT,        8'h00, 1'b0, NO_RESULT},
    '{SRC_LIT,        8'h80, 1'b0, NO_RESULT},
    '{SRC_LIT,        8'hFF, 1'b0, NO_RESULT},
    '{SRC_CRC_HI,     8'h00, 1'b0, NO_RESULT},
    '{SRC_CRC_LO_BAD, 8'h00, 1'b1, '{KIND_BADCRC, 8'h00, 8'h03}},
    '{SRC_LIT,        8'h7F, 1'b0, NO_RESULT}
  };

  crc16_framed_packet_deframer_top #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      x = x[15] ? ((x << 1) ^ CRC_POLY) : (x << 1);
    end
    return x;
  endfunction

  // Advances the predicted state by one received byte; returns 1 when a result is due.
  function automatic bit deframe_step(input logic [7:0] b, output deframe_result_t r);
    r = NO_RESULT;
    case (pred_phase)
      PH_LEN: begin
        if (b < MIN_LENGTH || int'(b) > MAX_PAYLOAD) begin
          pred_phase = PH_HUNT;
          r = '{KIND_BADLEN, 8'h00, b};
          return 1'b1;
        end
        pred_crc = crc_ccitt_byte(pred_crc, b);
        pred_len = b;
        pred_left = b;
        pred_phase = PH_DATA;
        return 1'b0;
      end
      PH_DATA: begin
        pred_crc = crc_ccitt_byte(pred_crc, b);
        pred_left = pred_left - 8'd1;
        if (pred_left == 8'd0) pred_phase = PH_CHK_HI;
        r = '{KIND_BYTE, b, pred_len};
        return 1'b1;
      end
      PH_CHK_HI: begin
        pred_chk_hi = b;
        pred_phase = PH_CHK_LO;
        return 1'b0;
      end
      PH_CHK_LO: begin
        pred_phase = PH_HUNT;
        r = '{({pred_chk_hi, b} == pred_crc) ? KIND_GOOD : KIND_BADCRC, 8'h00, pred_len};
        return 1'b1;
      end
      default: begin
        pred_phase = PH_HUNT;
        if (b == START_BYTE) begin
          pred_crc = crc_ccitt_byte(CRC_INIT, b);
          pred_phase = PH_LEN;
        end
        return 1'b0;
      end
    endcase
  endfunction

  // Offers one byte, waits for it to be taken, then records what it should produce.
  task automatic send_rx(input logic [7:0] b, input bit typed, input deframe_result_t typed_res);
    int gap;
    bit due;
    deframe_result_t r;
    gap = 0;
    if (idle_ok && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 15);
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    due = deframe_step(b, r);
    if (typed) expected_results_q.push_back(typed_res);
    else if (due) expected_results_q.push_back(r);
    rx_bytes_sent++;
  endtask

  task automatic send_frame(input int len, input int cut, input logic [15:0] crc_flip);
    logic [15:0] chk;
    send_rx(START_BYTE, 1'b0, NO_RESULT);
    send_rx(8'(len), 1'b0, NO_RESULT);
    for (int i = 0; i < len; i++) begin
      if (cut != 0 && i == cut) return;
      send_rx(8'($urandom), 1'b0, NO_RESULT);
    end
    chk = pred_crc ^ crc_flip;
    send_rx(chk[15:8], 1'b0, NO_RESULT);
    send_rx(chk[7:0], 1'b0, NO_RESULT);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    m_tready = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        m_tready <= 1'b1;
      end else if (idle_ok && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    deframe_result_t got;
    deframe_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tuser, m_tdata[7:0], m_tdata[15:8]};
      if (expected_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected item: kind %0d byte %02h length %0d",
                   got.kind, got.data, got.len);
      end else begin
        want = expected_results_q.pop_front();
        if (got.kind !== want.kind || got.data !== want.data || got.len !== want.len) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Item mismatch: expected kind %0d byte %02h length %0d, got kind %0d byte %02h length %0d",
                     want.kind, want.data, want.len, got.kind, got.data, got.len);
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int r;
    logic [7:0] b;
    bit calm;
    bit big_done;
    bit pressure_done;
    logic [7:0] noise;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    idle_ok = 1'b1;
    hold_req = 1'b0;
    mismatches = 0;
    rx_bytes_sent = 0;
    calm = 1'b0;
    big_done = 1'b0;
    pressure_done = 1'b0;
    pred_phase = PH_HUNT;
    pred_len = 8'h00;
    pred_left = 8'h00;
    pred_crc = CRC_INIT;
    pred_chk_hi = 8'h00;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      case (dir_rows[i].src)
        SRC_CRC_HI:     b = pred_crc[15:8];
        SRC_CRC_LO:     b = pred_crc[7:0];
        SRC_CRC_LO_BAD: b = pred_crc[7:0] ^ 8'h01;
        default:        b = dir_rows[i].rx;
      endcase
      send_rx(b, dir_rows[i].typed, dir_rows[i].res);
    end

    while (rx_bytes_sent < RX_BYTE_TARGET) begin
      if ($urandom_range(0, 7) == 0) calm = ~calm;
      idle_ok = !calm && rx_bytes_sent < RX_BYTE_TARGET - 60;
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          noise = 8'($urandom);
          if (noise == START_BYTE) noise = noise ^ 8'h01;
          send_rx(noise, 1'b0, NO_RESULT);
        end
      end
      r = $urandom_range(0, 19);
      if (!pressure_done && rx_bytes_sent > 250) begin
        // Long receiver stall while a frame keeps streaming in.
        hold_req = 1'b1;
        pressure_done = 1'b1;
        send_frame(40, 0, 16'h0000);
      end else if (!big_done && rx_bytes_sent > 150) begin
        big_done = 1'b1;
        send_frame(MAX_PAYLOAD, 0, 16'h0000);
      end else if (r == 0) begin
        send_rx(START_BYTE, 1'b0, NO_RESULT);
        send_rx(8'($urandom_range(0, 1)), 1'b0, NO_RESULT);
      end else if (r == 1) begin
        send_frame($urandom_range(20, 80), 0, 16'h0000);
      end else if (r == 2 || r == 3) begin
        send_frame($urandom_range(2, 12), 0, 16'h0001 << $urandom_range(0, 15));
      end else if (r == 4) begin
        // Frame cut short; whatever follows is taken as its payload.
        send_frame($urandom_range(4, 12), $urandom_range(1, 3), 16'h0000);
      end else begin
        send_frame($urandom_range(2, 12), 0, 16'h0000);
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_results_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_results_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[crc16_framed_packet_deframer_top.f]
+incdir+design
design/cfd_pkg.sv
design/cfd_crc_byte.sv
design/crc16_framed_packet_deframer_top.sv
design/cfd_checker.sv
tb/sv/crc16_framed_packet_deframer_top_tb.sv
